FILE: hdl/ita_pkg.sv
// ============================================================================
// ita_pkg
// Shared constants, types and helpers for the integer-to-ASCII formatter.
// ============================================================================
package ita_pkg;

    // Field widths of the stream payloads
    localparam int VIN_BITS   = 32;
    localparam int RADIX_BITS = 5;
    localparam int FW_BITS    = 6;
    localparam int CHAR_BITS  = 8;
    localparam int DIGIT_BITS = 4;

    // Input tdata layout, lowest bit first
    localparam int OFF_VALUE    = 0;
    localparam int OFF_RADIX    = OFF_VALUE + VIN_BITS;
    localparam int OFF_FW       = OFF_RADIX + RADIX_BITS;
    localparam int OFF_MD       = OFF_FW + FW_BITS;
    localparam int BIT_LEFT     = OFF_MD + FW_BITS;
    localparam int BIT_ZPAD     = BIT_LEFT + 1;
    localparam int BIT_SIGNED   = BIT_ZPAD + 1;
    localparam int BIT_PLUS     = BIT_SIGNED + 1;
    localparam int BIT_SPACE    = BIT_PLUS + 1;
    localparam int BIT_ALT      = BIT_SPACE + 1;
    localparam int BIT_LOWER    = BIT_ALT + 1;
    localparam int S_FIELD_BITS = BIT_LOWER + 1;
    localparam int S_TDATA_BITS = ((S_FIELD_BITS + 7) / 8) * 8;

    // Defaults for top-level parameters
    localparam int DEF_VALUE_BITS = 32;
    localparam int DEF_MAX_WIDTH  = 48;

    // Quotient bits resolved per divider cycle
    localparam int DIV_STEP = 4;

    // Radix limits and prefixed radices
    localparam logic [RADIX_BITS-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX = 5'd16;
    localparam logic [RADIX_BITS-1:0] RADIX_OCT = 5'd8;
    localparam logic [RADIX_BITS-1:0] RADIX_HEX = 5'd16;

    // Characters
    localparam int NUM_DIGITS = 16;
    localparam logic [NUM_DIGITS*CHAR_BITS-1:0] DIGIT_STR = "0123456789ABCDEF";
    localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_X     = 8'h58;
    localparam logic [CHAR_BITS-1:0] LC_MASK  = 8'h20;

    // Divider control and status
    typedef struct packed {
        logic start;   // load new dividend and divide
        logic again;   // divide the held quotient once more
    } div_ctrl_t;

    typedef struct packed {
        logic                  done;  // one-cycle pulse, remainder valid
        logic                  nz;    // quotient nonzero
        logic [DIGIT_BITS-1:0] rem;
    } div_stat_t;

    // Digit stack control
    typedef struct packed {
        logic push;
        logic pop;
    } stk_ctrl_t;

    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d,
                                                        input logic lc);
        logic [CHAR_BITS-1:0] ch;
        ch = DIGIT_STR[(NUM_DIGITS - 1 - int'(d)) * CHAR_BITS +: CHAR_BITS];
        return ch | (lc ? LC_MASK : CH_NUL);
    endfunction

endpackage

FILE: hdl/ita_div.sv
// ============================================================================
// ita_div
// Digit-serial restoring divider by a small radix, DIV_STEP bits per cycle.
// ============================================================================
module ita_div #(
    parameter int VALUE_BITS = ita_pkg::DEF_VALUE_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ita_pkg::div_ctrl_t               ctrl,
    input  logic [VALUE_BITS-1:0]            dividend,
    input  logic [ita_pkg::RADIX_BITS-1:0]   radix,
    output ita_pkg::div_stat_t               stat
);

    localparam int DIV_BITS   = ((VALUE_BITS + ita_pkg::DIV_STEP - 1) / ita_pkg::DIV_STEP)
                                * ita_pkg::DIV_STEP;
    localparam int DIV_CYCLES = DIV_BITS / ita_pkg::DIV_STEP;
    localparam int CNT_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    logic [DIV_BITS-1:0]            q_reg, q_w;
    logic [ita_pkg::DIGIT_BITS-1:0] rem_reg, rem_w;
    logic                           nz_reg, nz_w;
    logic [CNT_W-1:0]               cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    // DIV_STEP restoring steps on the narrow remainder
    always_comb
    begin
        logic [ita_pkg::RADIX_BITS-1:0] t;
        logic                           ge;
        q_w   = q_reg;
        rem_w = rem_reg;
        nz_w  = nz_reg;
        for (int j = 0; j < ita_pkg::DIV_STEP; j++)
        begin
            t  = {rem_w, q_w[DIV_BITS-1]};
            ge = (t >= radix);
            if (ge)
            begin
                t = t - radix;
            end
            rem_w = t[ita_pkg::DIGIT_BITS-1:0];
            q_w   = {q_w[DIV_BITS-2:0], ge};
            nz_w  = nz_w | ge;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            nz_reg   <= 1'b0;
            rem_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start || ctrl.again)
            begin
                if (ctrl.start)
                begin
                    q_reg <= DIV_BITS'(dividend);
                end
                rem_reg  <= '0;
                nz_reg   <= 1'b0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                q_reg   <= q_w;
                rem_reg <= rem_w;
                nz_reg  <= nz_w;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_CYCLES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.done = done_reg;
    assign stat.nz   = nz_reg;
    assign stat.rem  = rem_reg;

endmodule

FILE: hdl/ita_stack.sv
// ============================================================================
// ita_stack
// Digit stack as a shift register: digits go in low first, come out high first.
// ============================================================================
module ita_stack #(
    parameter int DEPTH = ita_pkg::DEF_VALUE_BITS
) (
    input  logic                           clk,
    input  ita_pkg::stk_ctrl_t             ctrl,
    input  logic [ita_pkg::DIGIT_BITS-1:0] din,
    output logic [ita_pkg::DIGIT_BITS-1:0] top_digit
);

    localparam int SR_BITS = DEPTH * ita_pkg::DIGIT_BITS;

    logic [SR_BITS-1:0] stk_reg;

    // push wins over pop; neither holds the contents
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            stk_reg <= {stk_reg[SR_BITS-ita_pkg::DIGIT_BITS-1:0], din};
        end
        else if (ctrl.pop)
        begin
            stk_reg <= {{ita_pkg::DIGIT_BITS{1'b0}}, stk_reg[SR_BITS-1:ita_pkg::DIGIT_BITS]};
        end
    end

    assign top_digit = stk_reg[ita_pkg::DIGIT_BITS-1:0];

endmodule

FILE: hdl/integer_to_ascii_formatter.sv
// ============================================================================
// integer_to_ascii_formatter
// printf-style integer to ASCII conversion, one character per output transaction.
// ============================================================================
// Usage:
//   s_axis carries one format request per transaction: value, radix, field
//   width, minimum digits and the flag bits (layout at the port). m_axis
//   returns the formatted characters one per transaction, tlast on the final
//   one. A radix outside 2..16 yields a single transaction with tdata 0,
//   tlast 1 and tuser 1.
//   Digits come from a divider that resolves 4 quotient bits per cycle; each
//   digit is one full division of the value, or of the held quotient, by the
//   radix. The divider is the bottleneck of a request: every digit is divided
//   out before the first character is valid, then one character per cycle
//   follows while the receiver keeps taking them.
//   One request is in flight at a time; s_axis_tready rises again once the
//   final character sits in the output register, so the next request can be
//   taken while that character waits.
//   A stalled receiver freezes the character stream; the output register holds
//   its transaction until taken. Reset empties the output register and returns
//   the sequencer to idle; nothing else needs clearing.
// ============================================================================
module integer_to_ascii_formatter #(
    parameter int VALUE_BITS = ita_pkg::DEF_VALUE_BITS,
    parameter int MAX_WIDTH  = ita_pkg::DEF_MAX_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // value[31:0], radix[36:32], min_width[42:37], min_digits[48:43],
    // left_align[49], zero_pad[50], signed_mode[51], plus_sign[52],
    // space_sign[53], alt_prefix[54], lower_case[55]
    input  logic [ita_pkg::S_TDATA_BITS-1:0]  s_axis_tdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // out_char[7:0]
    output logic [ita_pkg::CHAR_BITS-1:0]     m_axis_tdata,
    output logic                              m_axis_tlast,   // last_char
    output logic                              m_axis_tuser,   // bad_radix
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready
);

    localparam int PREC_MAX = (VALUE_BITS > MAX_WIDTH) ? VALUE_BITS : MAX_WIDTH;
    localparam int CNT_BITS = $clog2(PREC_MAX + 4);
    localparam int ND_BITS  = $clog2(VALUE_BITS + 1);

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_CALC  = 4'd2;
    localparam logic [3:0] S_START = 4'd3;
    localparam logic [3:0] S_LPAD  = 4'd4;
    localparam logic [3:0] S_SIGN  = 4'd5;
    localparam logic [3:0] S_PFX0  = 4'd6;
    localparam logic [3:0] S_PFXX  = 4'd7;
    localparam logic [3:0] S_ZPAD  = 4'd8;
    localparam logic [3:0] S_PREC  = 4'd9;
    localparam logic [3:0] S_DIG   = 4'd10;
    localparam logic [3:0] S_RPAD  = 4'd11;
    localparam logic [3:0] S_ERR   = 4'd12;

    // Prefix kinds
    localparam logic [1:0] PFX_NONE = 2'd0;
    localparam logic [1:0] PFX_OCT  = 2'd1;
    localparam logic [1:0] PFX_HEX  = 2'd2;

    // ---------------- input field decode ----------------
    logic [ita_pkg::VIN_BITS-1:0]   in_value;
    logic [ita_pkg::RADIX_BITS-1:0] in_radix;
    logic [ita_pkg::FW_BITS-1:0]    in_fw, in_md, fw_sat, md_sat;
    logic                           in_left, in_zp, in_signed, in_plus, in_space;
    logic                           in_alt, in_lower, in_accept, radix_ok;
    logic [VALUE_BITS-1:0]          mag_in, dividend;
    logic                           neg_in, has_sign_in;
    logic [ita_pkg::CHAR_BITS-1:0]  sign_ch_in;
    logic [1:0]                     pfx_in;

    assign in_value  = s_axis_tdata[ita_pkg::OFF_VALUE +: ita_pkg::VIN_BITS];
    assign in_radix  = s_axis_tdata[ita_pkg::OFF_RADIX +: ita_pkg::RADIX_BITS];
    assign in_fw     = s_axis_tdata[ita_pkg::OFF_FW +: ita_pkg::FW_BITS];
    assign in_md     = s_axis_tdata[ita_pkg::OFF_MD +: ita_pkg::FW_BITS];
    assign in_left   = s_axis_tdata[ita_pkg::BIT_LEFT];
    assign in_zp     = s_axis_tdata[ita_pkg::BIT_ZPAD];
    assign in_signed = s_axis_tdata[ita_pkg::BIT_SIGNED];
    assign in_plus   = s_axis_tdata[ita_pkg::BIT_PLUS];
    assign in_space  = s_axis_tdata[ita_pkg::BIT_SPACE];
    assign in_alt    = s_axis_tdata[ita_pkg::BIT_ALT];
    assign in_lower  = s_axis_tdata[ita_pkg::BIT_LOWER];

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign radix_ok  = (in_radix >= ita_pkg::RADIX_MIN) && (in_radix <= ita_pkg::RADIX_MAX);

    assign fw_sat = (in_fw > ita_pkg::FW_BITS'(MAX_WIDTH)) ? ita_pkg::FW_BITS'(MAX_WIDTH) : in_fw;
    assign md_sat = (in_md > ita_pkg::FW_BITS'(MAX_WIDTH)) ? ita_pkg::FW_BITS'(MAX_WIDTH) : in_md;

    // Value is cut or zero-extended to VALUE_BITS; negatives go in as magnitude
    assign mag_in   = VALUE_BITS'(in_value);
    assign neg_in   = in_signed && mag_in[VALUE_BITS-1];
    assign dividend = neg_in ? (~mag_in + VALUE_BITS'(1)) : mag_in;

    always_comb
    begin
        has_sign_in = 1'b1;
        priority if (neg_in)
        begin
            sign_ch_in = ita_pkg::CH_MINUS;
        end
        else if (in_signed && in_plus)
        begin
            sign_ch_in = ita_pkg::CH_PLUS;
        end
        else if (in_signed && in_space)
        begin
            sign_ch_in = ita_pkg::CH_SPACE;
        end
        else
        begin
            sign_ch_in  = ita_pkg::CH_NUL;
            has_sign_in = 1'b0;
        end

        priority if (in_alt && (in_radix == ita_pkg::RADIX_HEX))
        begin
            pfx_in = PFX_HEX;
        end
        else if (in_alt && (in_radix == ita_pkg::RADIX_OCT))
        begin
            pfx_in = PFX_OCT;
        end
        else
        begin
            pfx_in = PFX_NONE;
        end
    end

    // ---------------- request registers ----------------
    logic [ita_pkg::RADIX_BITS-1:0] radix_reg;
    logic [ita_pkg::FW_BITS-1:0]    fw_reg, md_reg;
    logic                           left_reg, zp_reg, lc_reg, has_sign_reg;
    logic [ita_pkg::CHAR_BITS-1:0]  sign_ch_reg;
    logic [1:0]                     pfx_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            radix_reg    <= in_radix;
            fw_reg       <= fw_sat;
            md_reg       <= md_sat;
            left_reg     <= in_left;
            zp_reg       <= in_zp && !in_left;   // left alignment beats zero padding
            lc_reg       <= in_lower;
            has_sign_reg <= has_sign_in;
            sign_ch_reg  <= sign_ch_in;
            pfx_reg      <= pfx_in;
        end
    end

    // ---------------- divider and digit stack ----------------
    ita_pkg::div_ctrl_t             div_ctrl;
    ita_pkg::div_stat_t             div_stat;
    ita_pkg::stk_ctrl_t             stk_ctrl;
    logic [ita_pkg::DIGIT_BITS-1:0] stk_top;

    ita_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (dividend),
        .radix    (radix_reg),
        .stat     (div_stat)
    );

    ita_stack #(
        .DEPTH (VALUE_BITS)
    ) u_stack (
        .clk       (clk),
        .ctrl      (stk_ctrl),
        .din       (div_stat.rem),
        .top_digit (stk_top)
    );

    // ---------------- sequencer ----------------
    logic [3:0]                    state_reg, state_next;
    logic [ND_BITS-1:0]            nd_reg, nd_next;
    logic [CNT_BITS-1:0]           pad_reg, pad_next;
    logic [CNT_BITS-1:0]           zeros_reg, zeros_next;
    logic                          m_valid_reg;
    logic [ita_pkg::CHAR_BITS-1:0] m_data_reg;
    logic                          m_last_reg, m_user_reg;
    logic                          emit_ok, out_ld, ld_last, ld_user;
    logic [ita_pkg::CHAR_BITS-1:0] ld_char, lc_mask;
    logic                          pad_nz;
    logic [3:0]                    e_prec, e_zpad, e_pfx0, e_sign, e_lpad;
    logic [CNT_BITS-1:0]           nd_ext, md_ext, fw_ext, prec, total;

    assign emit_ok = !m_valid_reg || m_axis_tready;
    assign pad_nz  = (pad_reg != '0);
    assign lc_mask = lc_reg ? ita_pkg::LC_MASK : ita_pkg::CH_NUL;

    // First non-empty section from each point of the field layout
    assign e_prec = (zeros_reg != '0) ? S_PREC : S_DIG;
    assign e_zpad = (zp_reg && pad_nz) ? S_ZPAD : e_prec;
    assign e_pfx0 = (pfx_reg != PFX_NONE) ? S_PFX0 : e_zpad;
    assign e_sign = has_sign_reg ? S_SIGN : e_pfx0;
    assign e_lpad = (!left_reg && !zp_reg && pad_nz) ? S_LPAD : e_sign;

    assign nd_ext = CNT_BITS'(nd_reg);
    assign md_ext = CNT_BITS'(md_reg);
    assign fw_ext = CNT_BITS'(fw_reg);
    assign prec   = (nd_ext > md_ext) ? nd_ext : md_ext;
    assign total  = CNT_BITS'(has_sign_reg) + CNT_BITS'(pfx_reg) + prec;

    always_comb
    begin
        state_next = state_reg;
        nd_next    = nd_reg;
        pad_next   = pad_reg;
        zeros_next = zeros_reg;
        div_ctrl   = '0;
        stk_ctrl   = '0;
        out_ld     = 1'b0;
        ld_char    = ita_pkg::CH_NUL;
        ld_last    = 1'b0;
        ld_user    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (radix_ok)
                    begin
                        div_ctrl.start = 1'b1;
                        nd_next        = '0;
                        state_next     = S_DIV;
                    end
                    else
                    begin
                        state_next = S_ERR;
                    end
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    stk_ctrl.push = 1'b1;
                    nd_next       = nd_reg + 1'b1;
                    if (div_stat.nz)
                    begin
                        div_ctrl.again = 1'b1;
                    end
                    else
                    begin
                        state_next = S_CALC;
                    end
                end
            end
            S_CALC:
            begin
                pad_next   = (fw_ext > total) ? (fw_ext - total) : '0;
                zeros_next = (md_ext > nd_ext) ? (md_ext - nd_ext) : '0;
                state_next = S_START;
            end
            S_START:
            begin
                state_next = e_lpad;
            end
            S_LPAD:
            begin
                if (emit_ok)
                begin
                    out_ld   = 1'b1;
                    ld_char  = ita_pkg::CH_SPACE;
                    pad_next = pad_reg - 1'b1;
                    if (pad_reg == CNT_BITS'(1))
                    begin
                        state_next = e_sign;
                    end
                end
            end
            S_SIGN:
            begin
                if (emit_ok)
                begin
                    out_ld     = 1'b1;
                    ld_char    = sign_ch_reg;
                    state_next = e_pfx0;
                end
            end
            S_PFX0:
            begin
                if (emit_ok)
                begin
                    out_ld     = 1'b1;
                    ld_char    = ita_pkg::CH_ZERO;
                    state_next = (pfx_reg == PFX_HEX) ? S_PFXX : e_zpad;
                end
            end
            S_PFXX:
            begin
                if (emit_ok)
                begin
                    out_ld     = 1'b1;
                    ld_char    = ita_pkg::CH_X | lc_mask;
                    state_next = e_zpad;
                end
            end
            S_ZPAD:
            begin
                if (emit_ok)
                begin
                    out_ld   = 1'b1;
                    ld_char  = ita_pkg::CH_ZERO;
                    pad_next = pad_reg - 1'b1;
                    if (pad_reg == CNT_BITS'(1))
                    begin
                        state_next = e_prec;
                    end
                end
            end
            S_PREC:
            begin
                if (emit_ok)
                begin
                    out_ld     = 1'b1;
                    ld_char    = ita_pkg::CH_ZERO;
                    zeros_next = zeros_reg - 1'b1;
                    if (zeros_reg == CNT_BITS'(1))
                    begin
                        state_next = S_DIG;
                    end
                end
            end
            S_DIG:
            begin
                if (emit_ok)
                begin
                    out_ld       = 1'b1;
                    ld_char      = ita_pkg::digit_char(stk_top, lc_reg);
                    stk_ctrl.pop = 1'b1;
                    nd_next      = nd_reg - 1'b1;
                    if (nd_reg == ND_BITS'(1))
                    begin
                        if (left_reg && pad_nz)
                        begin
                            state_next = S_RPAD;
                        end
                        else
                        begin
                            ld_last    = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            S_RPAD:
            begin
                if (emit_ok)
                begin
                    out_ld   = 1'b1;
                    ld_char  = ita_pkg::CH_SPACE;
                    pad_next = pad_reg - 1'b1;
                    if (pad_reg == CNT_BITS'(1))
                    begin
                        ld_last    = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_ERR:
            begin
                if (emit_ok)
                begin
                    out_ld     = 1'b1;
                    ld_char    = ita_pkg::CH_NUL;
                    ld_last    = 1'b1;
                    ld_user    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            nd_reg      <= '0;
            pad_reg     <= '0;
            zeros_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            nd_reg    <= nd_next;
            pad_reg   <= pad_next;
            zeros_reg <= zeros_next;
            if (out_ld)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (out_ld)
        begin
            m_data_reg <= ld_char;
            m_last_reg <= ld_last;
            m_user_reg <= ld_user;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

FILE: hdl/ita_checker.sv
// ============================================================================
// ita_checker
// Port-level checks for the integer-to-ASCII formatter, bound to the top level.
// ============================================================================
module ita_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [ita_pkg::CHAR_BITS-1:0]     m_axis_tdata,
    input logic                              m_axis_tlast,
    input logic                              m_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready
);

    // Error transaction ends its packet and carries a NUL
    a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == ita_pkg::CH_NUL))
        else $error("error transaction without tlast or with nonzero data");

    // One request at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken back to back");

    // Formatted characters stay in the printable range used by the formats
    a_printable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            (m_axis_tdata >= ita_pkg::CH_SPACE) && (m_axis_tdata <= 8'h7A))
        else $error("non-printable character emitted");

    // Stalled output transaction holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output transaction changed while stalled");

endmodule

bind integer_to_ascii_formatter ita_checker u_ita_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
